@@ sv/golay_23_12_codec_macros.svh @@
// Assertion macros used by the Golay(23,12) codec checker.
`ifndef GOLAY_23_12_CODEC_MACROS_SVH
`define GOLAY_23_12_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GOLAY_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GOLAY_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication that checks the consequent a fixed number of cycles after the next one.
`define GOLAY_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> ## dly (cons)) else $error(msg);

`endif

@@ sv/golay_pkg.sv @@
// Types, constants and division helpers for the Golay(23,12) codec.
package golay_pkg;

    localparam int WORD_W    = 23;
    localparam int INFO_W    = 12;
    localparam int SYN_W     = 11;
    localparam int BIT_IDX_W = 5;
    localparam int STEPS_PER_STAGE = 4;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [SYN_W-1:0]     t_syn;
    typedef logic [1:0]           t_func;
    typedef logic [BIT_IDX_W-1:0] t_bit_idx;
    typedef logic [WORD_W-1:0][SYN_W-1:0] t_col_tab;

    // Generator x^11+x^9+x^7+x^6+x^5+x+1.
    localparam t_word GEN_POLY = 23'h000AE3;

    localparam t_bit_idx LAST_BIT = t_bit_idx'(WORD_W - 1);

    // Operation codes.
    localparam t_func FUNC_ENCODE   = 2'd0;
    localparam t_func FUNC_SYNDROME = 2'd1;
    localparam t_func FUNC_CORRECT  = 2'd2;

    // One division step: fold in the generator when the low bit is set, then shift down.
    function automatic t_word f_div_step(t_word w);
        t_word v;
        v = w;
        if (v[0]) begin
            v = v ^ GEN_POLY;
        end
        return v >> 1;
    endfunction

    // Four division steps, the work of one pipeline stage.
    function automatic t_word f_div4(t_word w);
        t_word v;
        v = w;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            v = f_div_step(v);
        end
        return v;
    endfunction

    // Full remainder of a 23-bit word.
    function automatic t_syn f_syndrome(t_word w);
        t_word v;
        v = w;
        for (int k = 0; k < INFO_W; k++) begin
            v = f_div_step(v);
        end
        return v[SYN_W-1:0];
    endfunction

    // Syndrome of each single-bit word, worked out at elaboration.
    function automatic t_col_tab f_build_cols();
        t_col_tab tab;
        for (int i = 0; i < WORD_W; i++) begin
            tab[i] = f_syndrome(t_word'(1) << i);
        end
        return tab;
    endfunction

    localparam t_col_tab SYN_COL = f_build_cols();

endpackage

@@ sv/golay_23_12_codec.sv @@
// Golay(23,12) encoder, syndrome generator and three-error corrector, pipelined.
//
// Each item carries an operation and a 23-bit word. Encode places 11 check bits above the
// low 12 information bits; syndrome-only returns the 11-bit remainder in the result word;
// correct XORs the word with the coset leader of its syndrome (four or more errors give a
// wrong codeword). The unused operation code returns all zeros. The 12-step polynomial
// division runs as four steps in each of three register stages, the coset-leader memory
// read is registered alongside the last of them, and an output register follows. One item
// is taken every cycle while o_stall is low. After reset the 2048-entry coset-leader
// memory is filled by a sweep over all error patterns of weight one to three, one pattern a
// cycle, and o_stall stays high until the sweep is done.
module golay_23_12_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_func,
    input  logic [golay_pkg::WORD_W-1:0] i_data_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [golay_pkg::WORD_W-1:0] o_result_word,
    output logic [golay_pkg::SYN_W-1:0]  o_syndrome,
    output logic                       o_was_corrected
);

    localparam int REM1_W = golay_pkg::WORD_W - golay_pkg::STEPS_PER_STAGE;
    localparam int REM2_W = REM1_W - golay_pkg::STEPS_PER_STAGE;

    // Coset-leader memory and its fill sweep.
    golay_pkg::t_word    r_lead_rom [0:(1 << golay_pkg::SYN_W)-1];
    logic                r_fill_busy;
    golay_pkg::t_bit_idx r_fill_a, r_fill_b, r_fill_c;
    logic                n_fill_busy;
    golay_pkg::t_bit_idx n_fill_a, n_fill_b, n_fill_c;
    golay_pkg::t_word    fill_pat;
    golay_pkg::t_syn     fill_syn;

    // Pipeline registers.
    logic                r1_v, r2_v, r3_v, r4_v;
    golay_pkg::t_func    r1_func, r2_func, r3_func;
    golay_pkg::t_word    r1_word, r2_word, r3_word;
    logic [REM1_W-1:0]   r1_rem;
    logic [REM2_W-1:0]   r2_rem;
    golay_pkg::t_syn     r3_syn;
    golay_pkg::t_word    r3_lead;
    golay_pkg::t_word    r4_result;
    golay_pkg::t_syn     r4_syn;
    logic                r4_corr;

    logic                adv1, adv2, adv3, adv4;
    golay_pkg::t_word    n_dividend;
    golay_pkg::t_word    div1, div2, div3;
    logic [REM1_W-1:0]   n_rem1;
    logic [REM2_W-1:0]   n_rem2;
    golay_pkg::t_syn     n_syn3;
    golay_pkg::t_word    n_result;
    golay_pkg::t_syn     n_syn4;
    logic                n_corr;

    // A stage moves on when it is empty or the stage after it moves on.
    assign adv4 = !r4_v || !i_stall;
    assign adv3 = !r3_v || adv4;
    assign adv2 = !r2_v || adv3;
    assign adv1 = !r1_v || adv2;

    assign o_stall = !adv1 || r_fill_busy;

    // Fill sweep walks all index triples a <= b <= c, which covers every pattern of weight 1 to 3.
    always_comb begin
        n_fill_a    = r_fill_a;
        n_fill_b    = r_fill_b;
        n_fill_c    = r_fill_c;
        n_fill_busy = 1'b1;
        if (r_fill_c != golay_pkg::LAST_BIT) begin
            n_fill_c = r_fill_c + golay_pkg::t_bit_idx'(1);
        end else if (r_fill_b != golay_pkg::LAST_BIT) begin
            n_fill_b = r_fill_b + golay_pkg::t_bit_idx'(1);
            n_fill_c = r_fill_b + golay_pkg::t_bit_idx'(1);
        end else if (r_fill_a != golay_pkg::LAST_BIT) begin
            n_fill_a = r_fill_a + golay_pkg::t_bit_idx'(1);
            n_fill_b = r_fill_a + golay_pkg::t_bit_idx'(1);
            n_fill_c = r_fill_a + golay_pkg::t_bit_idx'(1);
        end else begin
            n_fill_busy = 1'b0;
        end
    end

    // The pattern's syndrome is the XOR of the columns of its distinct set bits.
    always_comb begin
        fill_pat = (golay_pkg::t_word'(1) << r_fill_a) | (golay_pkg::t_word'(1) << r_fill_b)
                 | (golay_pkg::t_word'(1) << r_fill_c);
        fill_syn = golay_pkg::SYN_COL[r_fill_a];
        if (r_fill_b != r_fill_a) begin
            fill_syn = fill_syn ^ golay_pkg::SYN_COL[r_fill_b];
        end
        if (r_fill_c != r_fill_b) begin
            fill_syn = fill_syn ^ golay_pkg::SYN_COL[r_fill_c];
        end
    end

    // Fill sweep control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_a    <= '0;
            r_fill_b    <= '0;
            r_fill_c    <= '0;
        end else if (r_fill_busy) begin
            r_fill_busy <= n_fill_busy;
            r_fill_a    <= n_fill_a;
            r_fill_b    <= n_fill_b;
            r_fill_c    <= n_fill_c;
        end
    end

    // Coset-leader memory write port, used only by the fill sweep.
    always_ff @(posedge i_clk) begin
        if (r_fill_busy) begin
            r_lead_rom[fill_syn] <= fill_pat;
        end
    end

    // Division datapath: four steps per stage; encode divides only the information bits.
    always_comb begin
        if (i_func == golay_pkg::FUNC_ENCODE) begin
            n_dividend = {{(golay_pkg::WORD_W-golay_pkg::INFO_W){1'b0}},
                          i_data_word[golay_pkg::INFO_W-1:0]};
        end else begin
            n_dividend = i_data_word;
        end
        div1   = golay_pkg::f_div4(n_dividend);
        n_rem1 = div1[REM1_W-1:0];
        div2   = golay_pkg::f_div4({{(golay_pkg::WORD_W-REM1_W){1'b0}}, r1_rem});
        n_rem2 = div2[REM2_W-1:0];
        div3   = golay_pkg::f_div4({{(golay_pkg::WORD_W-REM2_W){1'b0}}, r2_rem});
        n_syn3 = div3[golay_pkg::SYN_W-1:0];
    end

    // Result selection per operation.
    always_comb begin
        n_result = '0;
        n_syn4   = '0;
        n_corr   = 1'b0;
        case (r3_func)
            golay_pkg::FUNC_ENCODE: begin
                n_result = {r3_syn, r3_word[golay_pkg::INFO_W-1:0]};
            end
            golay_pkg::FUNC_SYNDROME: begin
                n_result = {{(golay_pkg::WORD_W-golay_pkg::SYN_W){1'b0}}, r3_syn};
                n_syn4   = r3_syn;
            end
            golay_pkg::FUNC_CORRECT: begin
                n_syn4 = r3_syn;
                if (r3_syn != '0) begin
                    n_result = r3_word ^ r3_lead;
                    n_corr   = 1'b1;
                end else begin
                    n_result = r3_word;
                end
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (adv1) begin
                r1_v <= i_valid && !r_fill_busy;
            end
            if (adv2) begin
                r2_v <= r1_v;
            end
            if (adv3) begin
                r3_v <= r2_v;
            end
            if (adv4) begin
                r4_v <= r3_v;
            end
        end
    end

    // Payload registers; the coset-leader read is registered with the final division stage.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_func <= i_func;
            r1_word <= n_dividend;
            r1_rem  <= n_rem1;
        end
        if (adv2) begin
            r2_func <= r1_func;
            r2_word <= r1_word;
            r2_rem  <= n_rem2;
        end
        if (adv3) begin
            r3_func <= r2_func;
            r3_word <= r2_word;
            r3_syn  <= n_syn3;
            r3_lead <= r_lead_rom[n_syn3];
        end
        if (adv4) begin
            r4_result <= n_result;
            r4_syn    <= n_syn4;
            r4_corr   <= n_corr;
        end
    end

    assign o_valid         = r4_v;
    assign o_result_word   = r4_result;
    assign o_syndrome      = r4_syn;
    assign o_was_corrected = r4_corr;

endmodule

@@ sv/golay_checker.sv @@
// Port-level checker for the Golay(23,12) codec and its bind to the top level.
`include "golay_23_12_codec_macros.svh"

module golay_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [1:0]                   i_func,
    input logic [golay_pkg::WORD_W-1:0] i_data_word,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [golay_pkg::WORD_W-1:0] o_result_word,
    input logic [golay_pkg::SYN_W-1:0]  o_syndrome,
    input logic                         o_was_corrected
);

    // A stalled result item holds its payload.
    `GOLAY_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_word) && $stable(o_syndrome) && $stable(o_was_corrected), "stalled result item changed")

    // Correction happens only for a nonzero syndrome.
    `GOLAY_ASSERT_IMPL(a_corr_syn, i_clk, i_rst_n, o_valid && o_was_corrected, o_syndrome != '0, "correction flagged with zero syndrome")

    // A corrected word is always a codeword.
    `GOLAY_ASSERT_IMPL(a_corr_cw, i_clk, i_rst_n, o_valid && o_was_corrected, golay_pkg::f_syndrome(o_result_word) == '0, "corrected word is not a codeword")

    // An accepted item reaches the output register.
    `GOLAY_ASSERT_DELAY(a_latency, i_clk, i_rst_n, i_valid && !o_stall, 3, o_valid, "accepted item did not reach the output")

endmodule

bind golay_23_12_codec golay_checker u_golay_checker (.*);
